// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the queue RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define BRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition implies a property at the next edge
`define BRQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/brq_pkg.sv -----
// Package for the byte ring queue: request codes, status struct, defaults.
// No dependencies.
package brq_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int REQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_DISCARD = 3'd2,
        REQ_PEEK    = 3'd3,
        REQ_RESET   = 3'd4
    } brq_req_t;

    typedef struct packed {
        logic error;
        logic is_empty;
        logic is_full;
        logic rd_ok;
    } brq_status_t;

endpackage

// ----- rtl/core/brq_ram.sv -----
// Ring storage for the byte queue: one write port, one registered read port.
// Depends on brq_pkg for the byte width.
module brq_ram #(
    parameter int DEPTH = brq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [brq_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [brq_pkg::BYTE_W-1:0] rdata
);

    logic [brq_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [brq_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/brq_ctrl.sv -----
// Pointer and free-count control for the byte ring queue.
// Depends on brq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brq_ctrl #(
    parameter int DEPTH = brq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [brq_pkg::REQ_W-1:0]  req_type,
    input  logic [brq_pkg::BYTE_W-1:0] amount,
    output logic                       we,
    output logic [AW-1:0]              waddr,
    output logic [AW-1:0]              raddr,
    output brq_pkg::brq_status_t       status,
    output logic [brq_pkg::CNT_W-1:0]  free_count,
    output logic [brq_pkg::CNT_W-1:0]  used_count
);

    localparam int CAPACITY = DEPTH - 1;
    localparam int CW       = (AW > brq_pkg::CNT_W) ? AW : brq_pkg::CNT_W;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] free_reg, free_next;
    logic [AW-1:0] used_now, used_after;
    logic [CW-1:0] amt_w, used_w, free_out_w, used_out_w;
    logic [AW-1:0] amt_p;
    brq_pkg::brq_status_t st;
    logic          ok;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign used_now = AW'(CAPACITY) - free_reg;
    assign amt_w    = CW'(amount);
    assign used_w   = CW'(used_now);
    assign amt_p    = amt_w[AW-1:0];

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        free_next = free_reg;
        raddr     = head_reg;
        ok        = 1'b0;
        st        = '0;
        unique case (req_type)
            brq_pkg::REQ_PUSH: begin
                if (free_reg == '0) begin
                    st.error = 1'b1;
                end else begin
                    ok        = 1'b1;
                    tail_next = wrap_add(tail_reg, AW'(1));
                    free_next = free_reg - AW'(1);
                end
            end
            brq_pkg::REQ_POP: begin
                if (used_now == '0) begin
                    st.error = 1'b1;
                end else begin
                    st.rd_ok  = 1'b1;
                    head_next = wrap_add(head_reg, AW'(1));
                    free_next = free_reg + AW'(1);
                end
            end
            brq_pkg::REQ_DISCARD: begin
                if (amt_w > used_w) begin
                    st.error = 1'b1;
                end else begin
                    head_next = wrap_add(head_reg, amt_p);
                    free_next = free_reg + amt_p;
                end
            end
            brq_pkg::REQ_PEEK: begin
                if (amt_w >= used_w) begin
                    st.error = 1'b1;
                end else begin
                    st.rd_ok = 1'b1;
                    raddr    = wrap_add(head_reg, amt_p);
                end
            end
            brq_pkg::REQ_RESET: begin
                head_next = '0;
                tail_next = '0;
                free_next = AW'(CAPACITY);
            end
            default: begin
                st.error = 1'b1;
            end
        endcase
        used_after  = AW'(CAPACITY) - free_next;
        st.is_empty = (used_after == '0);
        st.is_full  = (free_next == '0);
    end

    assign we         = accept & ok;
    assign waddr      = tail_reg;
    assign status     = st;
    assign free_out_w = CW'(free_next);
    assign used_out_w = CW'(used_after);
    assign free_count = free_out_w[brq_pkg::CNT_W-1:0];
    assign used_count = used_out_w[brq_pkg::CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            free_reg <= AW'(CAPACITY);
        end else if (accept) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
        end
    end

    `BRQ_ASSERT(a_free_in_range, free_reg <= AW'(CAPACITY), "free count above capacity")
    `BRQ_ASSERT(a_ptr_gap_matches_used,
        wrap_add(tail_reg, AW'(DEPTH) - head_reg) == used_now, "pointer gap differs from used count")
    `BRQ_ASSERT(a_no_write_when_full, !(we && free_reg == '0), "write issued while full")
    `BRQ_ASSERT_NEXT(a_error_holds_state, accept && st.error,
        $stable(head_reg) && $stable(tail_reg) && $stable(free_reg), "refused request moved state")

endmodule

// ----- rtl/core/byte_ring_queue_peek_discard.sv -----
// Top level of the byte ring queue with peek and discard requests.
// Depends on brq_pkg, brq_ctrl and brq_ram.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the request kind
//   (push, pop, discard, peek, reset), s_tdata the byte to push and the
//   discard count or peek offset. Each accepted request yields exactly one
//   result transfer on the m_ channel with the byte read, an error flag,
//   empty and full flags and the free and used counts after the request.
//   Results are registered: a request accepted at a clock edge is presented on m_
//   from the next edge on. One request per cycle is sustained while the
//   receiver takes each result; the pointers update in a single add-and-wrap
//   and the ring has one write and one registered read port.
//   Reset (aresetn low) empties the queue: pointers to zero, free count to
//   DEPTH-1, no result pending. Ring contents are not cleared.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken; a new request enters in the same
//   cycle that the held result transfers.
module byte_ring_queue_peek_discard #(
    parameter int DEPTH = brq_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_in, [15:8] amount
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] data_out, [8] error, [9] is_empty,
                                   // [10] is_full, [18:11] free_count,
                                   // [26:19] used_count, [31:27] zero
);

    localparam int AW = $clog2(DEPTH);

    logic                       accept;
    logic                       we;
    logic [AW-1:0]              waddr, raddr;
    logic [brq_pkg::BYTE_W-1:0] rdata;
    brq_pkg::brq_status_t       status, status_reg;
    logic [brq_pkg::CNT_W-1:0]  free_count, used_count;
    logic [brq_pkg::CNT_W-1:0]  free_reg, used_reg;
    logic                       m_tvalid_reg;
    logic [brq_pkg::BYTE_W-1:0] data_out;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    brq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req_type   (s_tuser),
        .amount     (s_tdata[15:8]),
        .we         (we),
        .waddr      (waddr),
        .raddr      (raddr),
        .status     (status),
        .free_count (free_count),
        .used_count (used_count)
    );

    brq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_tdata[7:0]),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status;
            free_reg   <= free_count;
            used_reg   <= used_count;
        end
    end

    assign data_out = status_reg.rd_ok ? rdata : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, used_reg, free_reg, status_reg.is_full,
                       status_reg.is_empty, status_reg.error, data_out};

endmodule
